// ----- rtl/fqem_pkg.sv -----
// ----------------------------------------------------------------------------
// fqem_pkg
// Shared constants, codes and types of the ordered queue with extract-min.
// ----------------------------------------------------------------------------
package fqem_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = IDX_W + 1;

	// fixed field widths at the ports
	localparam int VALUE_FIELD_W = 16;
	localparam int COUNT_FIELD_W = 7;
	localparam int ACTION_W      = 2;
	localparam int STATUS_W      = 2;
	localparam int CAP_W         = 7;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_EXT = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} seq_state_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [VALUE_BITS-1:0] wdata;
		logic [IDX_W-1:0]      raddr;
	} ram_req_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} seq_stat_t;

	// capacity clipped to the store depth
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		if (int'(cap) > DEPTH)
			return CNT_W'(DEPTH);
		else
			return CNT_W'(cap);
	endfunction

endpackage

// ----- rtl/fqem_if.sv -----
// ----------------------------------------------------------------------------
// fqem_in_if / fqem_out_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface fqem_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [fqem_pkg::ACTION_W-1:0]         action;
	logic [fqem_pkg::VALUE_FIELD_W-1:0]    value_in;

	modport source (output valid, output action, output value_in, input ready);
	modport sink (input valid, input action, input value_in, output ready);
endinterface

interface fqem_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [fqem_pkg::VALUE_FIELD_W-1:0]    value_out;
	logic [fqem_pkg::STATUS_W-1:0]         status;
	logic [fqem_pkg::COUNT_FIELD_W-1:0]    count;
	logic                                  is_full;
	logic                                  is_empty;

	modport source (output valid, output value_out, output status, output count,
		output is_full, output is_empty, input ready);
	modport sink (input valid, input value_out, input status, input count,
		input is_full, input is_empty, output ready);
endinterface

// ----- rtl/fqem_ram.sv -----
// ----------------------------------------------------------------------------
// fqem_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fqem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/fqem_apb.sv -----
// ----------------------------------------------------------------------------
// fqem_apb
// Configuration register file: holds the queue capacity.
// ----------------------------------------------------------------------------
module fqem_apb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fqem_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fqem_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fqem_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [fqem_pkg::CAP_W-1:0]          capacity
);

	logic [fqem_pkg::CAP_W-1:0]     capacity_q;
	logic [fqem_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[fqem_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fqem_pkg::CAP_RESET;
		end else if (wr_en && reg_idx == fqem_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[fqem_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		if (reg_idx == fqem_pkg::REG_CAPACITY)
			prdata = fqem_pkg::APB_DATA_W'(capacity_q);
		else
			prdata = '0;
	end

	assign capacity = capacity_q;

endmodule

// ----- rtl/fqem_seq.sv -----
// ----------------------------------------------------------------------------
// fqem_seq
// Command sequencer: min scan through one shared comparator, then an
// entry-by-entry shift that closes the gap, plus the result register.
// ----------------------------------------------------------------------------
module fqem_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [fqem_pkg::CAP_W-1:0]           capacity,
	fqem_in_if.sink                              in_ch,
	fqem_out_if.source                           out_ch,
	output fqem_pkg::ram_req_t                   ram_req,
	input  logic [fqem_pkg::VALUE_BITS-1:0]      ram_rdata,
	output fqem_pkg::seq_stat_t                  stat
);

	localparam int CW = fqem_pkg::CNT_W;
	localparam int IW = fqem_pkg::IDX_W;
	localparam int VW = fqem_pkg::VALUE_BITS;

	fqem_pkg::seq_state_t state_q, state_d;
	fqem_pkg::action_t    act;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] last_q;
	logic          rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;
	logic [VW-1:0] best_val_q;
	logic [CW-1:0] best_idx_q;
	logic [CW-1:0] best_idx_d;
	logic [CW-1:0] eff_cap;
	logic [CW-1:0] shift_waddr;

	logic accept, issue, lt, take, scan_end, shift_end, start_op;

	logic                  res_load;
	logic [VW-1:0]         res_val;
	fqem_pkg::status_t     res_stat;
	logic [CW-1:0]         res_cnt;

	logic                  out_vld_q;
	logic [VW-1:0]         out_val_q;
	fqem_pkg::status_t     out_stat_q;
	logic [CW-1:0]         out_cnt_q;
	logic                  out_full_q;
	logic                  out_empty_q;

	assign eff_cap = fqem_pkg::eff_cap(capacity);
	assign act     = fqem_pkg::action_t'(in_ch.action);
	assign in_ch.ready = (state_q == fqem_pkg::S_IDLE) && (!out_vld_q || out_ch.ready);
	assign accept  = in_ch.valid && in_ch.ready;
	assign start_op = accept && (act == fqem_pkg::ACT_DEQ || act == fqem_pkg::ACT_EXT) &&
		(count_q != '0);

	// one read per cycle while the index is inside the active range
	assign issue = (state_q == fqem_pkg::S_SCAN || state_q == fqem_pkg::S_SHIFT) &&
		(idx_q <= last_q);

	// shared comparator; strict less keeps the earliest entry on ties
	assign lt   = ram_rdata < best_val_q;
	assign take = (state_q == fqem_pkg::S_SCAN) && rd_vld_s1 && (rd_idx_s1 == '0 || lt);
	assign best_idx_d = take ? rd_idx_s1 : best_idx_q;

	assign scan_end  = (state_q == fqem_pkg::S_SCAN) && rd_vld_s1 && (rd_idx_s1 == last_q);
	assign shift_end = (state_q == fqem_pkg::S_SHIFT) && !rd_vld_s1 && (idx_q > last_q);
	assign shift_waddr = rd_idx_s1 - CW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fqem_pkg::S_IDLE: begin
				if (start_op)
					state_d = fqem_pkg::S_SCAN;
			end
			fqem_pkg::S_SCAN: begin
				if (scan_end)
					state_d = fqem_pkg::S_SHIFT;
			end
			fqem_pkg::S_SHIFT: begin
				if (shift_end)
					state_d = fqem_pkg::S_IDLE;
			end
			default: state_d = fqem_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = shift_waddr[IW-1:0];
		ram_req.wdata = ram_rdata;
		ram_req.raddr = idx_q[IW-1:0];
		res_load = 1'b0;
		res_val  = '0;
		res_stat = fqem_pkg::STAT_DONE;
		res_cnt  = count_q;
		case (state_q)
			fqem_pkg::S_IDLE: begin
				if (accept) begin
					case (act)
						fqem_pkg::ACT_ENQ: begin
							res_load = 1'b1;
							if (count_q < eff_cap) begin
								ram_req.we    = 1'b1;
								ram_req.waddr = count_q[IW-1:0];
								ram_req.wdata = in_ch.value_in[VW-1:0];
								res_cnt       = count_q + CW'(1);
							end else begin
								res_stat = fqem_pkg::STAT_FULL;
							end
						end
						fqem_pkg::ACT_DEQ, fqem_pkg::ACT_EXT: begin
							if (count_q == '0) begin
								res_load = 1'b1;
								res_stat = fqem_pkg::STAT_EMPTY;
							end
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			fqem_pkg::S_SHIFT: begin
				// entry j read last cycle moves down to j-1
				ram_req.we = rd_vld_s1;
				if (shift_end) begin
					res_load = 1'b1;
					res_val  = best_val_q;
					res_cnt  = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fqem_pkg::S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			last_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (res_load)
				count_q <= res_cnt;
			if (start_op) begin
				idx_q  <= '0;
				last_q <= (act == fqem_pkg::ACT_DEQ) ? '0 : count_q - CW'(1);
			end else if (scan_end) begin
				idx_q  <= best_idx_d + CW'(1);
				last_q <= count_q - CW'(1);
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (res_load)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (take) begin
			best_val_q <= ram_rdata;
			best_idx_q <= rd_idx_s1;
		end
		if (res_load) begin
			out_val_q   <= res_val;
			out_stat_q  <= res_stat;
			out_cnt_q   <= res_cnt;
			out_full_q  <= res_cnt >= eff_cap;
			out_empty_q <= res_cnt == '0;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.value_out = fqem_pkg::VALUE_FIELD_W'(out_val_q);
	assign out_ch.status    = out_stat_q;
	assign out_ch.count     = fqem_pkg::COUNT_FIELD_W'(out_cnt_q);
	assign out_ch.is_full   = out_full_q;
	assign out_ch.is_empty  = out_empty_q;

	assign stat.busy  = state_q != fqem_pkg::S_IDLE;
	assign stat.count = count_q;

endmodule

// ----- rtl/fifo_queue_with_extract_min.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_extract_min
// Bounded ordered queue with enqueue, dequeue-oldest and extract-minimum.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          action, value_in
//  out_ch   out  valid/ready          value_out, status, count, is_full, is_empty
//  apb      in   psel/penable/pready  capacity register at offset 0
//
//  Enqueue, no-op and empty/full refusals: result registered at the accepting edge.
//  Dequeue and extract-min both run a scan and a gap-closing shift through the
//  single store read port, one entry per cycle. Reset empties the queue and sets
//  capacity to 64. in_ch.ready is low while an operation runs or an unaccepted
//  result would be overwritten.
// ----------------------------------------------------------------------------
module fifo_queue_with_extract_min (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fqem_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [fqem_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [fqem_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	fqem_in_if.sink                          in_ch,
	fqem_out_if.source                       out_ch
);

	logic [fqem_pkg::CAP_W-1:0]      capacity;
	fqem_pkg::ram_req_t              ram_req;
	logic [fqem_pkg::VALUE_BITS-1:0] ram_rdata;
	fqem_pkg::seq_stat_t             stat;

	fqem_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	fqem_ram #(
		.WIDTH (fqem_pkg::VALUE_BITS),
		.DEPTH (fqem_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	fqem_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.stat      (stat)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= fqem_pkg::CNT_W'(fqem_pkg::DEPTH))
		else $error("entry count above store depth");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (stat.busy || out_ch.valid))
		else $error("accepted transfer produced neither work nor result");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !in_ch.ready)
		else $error("input ready while an operation runs");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.busy) |-> out_ch.valid)
		else $error("operation finished without a result");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == fqem_pkg::STAT_EMPTY) |->
		(out_ch.value_out == '0 && out_ch.is_empty))
		else $error("empty status with nonzero value or count");

endmodule
